>>> rtl/tlg5pdf_pkg.sv
// Package for the TLG5 pixel delta filter: shared constants, register codes
// and the word type carried from the front end to the back end.
// No dependencies.
package tlg5pdf_pkg;

   // Default sizing for the top-level parameters
   localparam int MAX_WIDTH_DEFAULT   = 4096;
   localparam int BLOCK_ROWS_DEFAULT  = 4;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Fixed field and register widths
   localparam int CHANNEL_BITS    = 8;
   localparam int CHANNELS        = 4;
   localparam int PIXEL_BITS      = CHANNEL_BITS * CHANNELS;
   localparam int WIDTH_REG_BITS  = 13;
   localparam int HEIGHT_REG_BITS = 16;
   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 32;
   localparam int USER_BITS       = 2;

   // Register index, taken from the word address
   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   // Image geometry as programmed
   typedef struct packed {
      logic [WIDTH_REG_BITS-1:0]  image_width;
      logic [HEIGHT_REG_BITS-1:0] image_height;
   } config_type;

   // Classified pixel with the pixel above it from the line store
   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic [PIXEL_BITS-1:0] above;
      logic                  first_row;
      logic                  first_col;
      logic                  row_end;
      logic                  block_end;
      logic                  frame_end;
   } item_type;

endpackage

>>> rtl/tlg5_pixel_delta_filter.sv
// Top level of the TLG5 pixel delta filter: register port, front end, queue
// and back end. Depends on tlg5pdf_pkg, tlg5pdf_front, tlg5pdf_queue, tlg5pdf_back.
//
//   channel  | direction | words                         | handshake
//   req_     | in        | one BGRA pixel, raster order  | tvalid/tready
//   rsp_     | out       | four residual planes + marks  | tvalid/tready
//   csr_     | in/out    | image_width, image_height     | psel/penable, pready high
//
// Sustains one pixel per cycle while rsp_tready is high; rsp_tvalid is set
// through three registers in line: the front stage (which also takes the
// line-store read data), a queue entry and the output register.
// Synchronous reset clears counters, running deltas and handshake state; the
// line store is not cleared and is undefined until a row has been written.
// With rsp_tready low, six words are taken in (front stage, four queue entries,
// output register) before req_tready drops.
module tlg5_pixel_delta_filter #(
   parameter int MAX_WIDTH   = tlg5pdf_pkg::MAX_WIDTH_DEFAULT,
   parameter int BLOCK_ROWS  = tlg5pdf_pkg::BLOCK_ROWS_DEFAULT,
   parameter int QUEUE_DEPTH = tlg5pdf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // tdata: blue [7:0], green [15:8], red [23:16], alpha [31:24]
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [tlg5pdf_pkg::PIXEL_BITS-1:0]      req_tdata,
   // tdata: plane_blue_minus_green [7:0], plane_green [15:8],
   //        plane_red_minus_green [23:16], plane_alpha [31:24]
   // tuser: row_end [0], block_end [1]; tlast: frame_end
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [tlg5pdf_pkg::PIXEL_BITS-1:0]      rsp_tdata,
   output logic [tlg5pdf_pkg::USER_BITS-1:0]       rsp_tuser,
   output logic                                    rsp_tlast,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [tlg5pdf_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [tlg5pdf_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [tlg5pdf_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                    csr_pready
);

   localparam int WB = tlg5pdf_pkg::WIDTH_REG_BITS;
   localparam int HB = tlg5pdf_pkg::HEIGHT_REG_BITS;
   localparam int DB = tlg5pdf_pkg::CSR_DATA_BITS;

   logic [WB-1:0] width_ff, width_in;
   logic [HB-1:0] height_ff, height_in;
   logic          csr_write;
   tlg5pdf_pkg::reg_index_type reg_index;
   tlg5pdf_pkg::config_type    cfg;

   logic                  q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
   tlg5pdf_pkg::item_type q_push_item, q_pop_item;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = tlg5pdf_pkg::reg_index_type'(csr_paddr[2]);

   // Decode register writes and reads
   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      csr_prdata = '0;
      unique case (reg_index)
         tlg5pdf_pkg::REG_IMAGE_WIDTH: begin
            if (csr_write) width_in = csr_pwdata[WB-1:0];
            csr_prdata = DB'(width_ff);
         end
         tlg5pdf_pkg::REG_IMAGE_HEIGHT: begin
            if (csr_write) height_in = csr_pwdata[HB-1:0];
            csr_prdata = DB'(height_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WB'(1);
         height_ff <= HB'(1);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign cfg.image_width  = width_ff;
   assign cfg.image_height = height_ff;

   tlg5pdf_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .BLOCK_ROWS (BLOCK_ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .item_valid (q_push_valid),
      .item_ready (q_push_ready),
      .item       (q_push_item)
   );

   tlg5pdf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_item  (q_push_item),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_item   (q_pop_item)
   );

   tlg5pdf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_pop_valid),
      .item_ready (q_pop_ready),
      .item       (q_pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> rtl/tlg5pdf_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tlg5pdf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read old contents before a write to the same address lands
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/tlg5pdf_front.sv
// Front end: accepts pixels, keeps column, row and block counters, marks
// row/block/frame ends and fetches the pixel above from the line store.
// Depends on tlg5pdf_pkg and tlg5pdf_ram.
module tlg5pdf_front #(
   parameter int MAX_WIDTH  = tlg5pdf_pkg::MAX_WIDTH_DEFAULT,
   parameter int BLOCK_ROWS = tlg5pdf_pkg::BLOCK_ROWS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tlg5pdf_pkg::config_type             cfg,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tlg5pdf_pkg::PIXEL_BITS-1:0]  req_tdata,
   output logic                                item_valid,
   input  logic                                item_ready,
   output tlg5pdf_pkg::item_type               item
);

   localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int BRW  = (BLOCK_ROWS > 1) ? $clog2(BLOCK_ROWS) : 1;
   localparam int CMPW = 18;
   localparam int HB   = tlg5pdf_pkg::HEIGHT_REG_BITS;

   // Position counters
   logic [CW-1:0]  col_ff, col_in;
   logic [HB-1:0]  row_ff, row_in;
   logic [BRW-1:0] brow_ff, brow_in;

   // Stage holding the accepted pixel while the line store answers
   logic                                fr_valid_ff, fr_valid_in;
   logic [tlg5pdf_pkg::PIXEL_BITS-1:0]  pix_ff;
   logic                                first_row_ff, first_col_ff;
   logic                                row_end_ff, block_end_ff, frame_end_ff;

   logic                                accept;
   logic [CMPW-1:0]                     col_next, width_sat;
   logic [HB:0]                         row_next, height_sat;
   logic                                last_col, last_row, last_brow;
   logic [tlg5pdf_pkg::PIXEL_BITS-1:0]  above;

   assign req_tready = !fr_valid_ff || item_ready;
   assign accept     = req_tvalid && req_tready;

   // Classify the position; zero width or height counts as one
   always_comb begin
      width_sat  = (cfg.image_width == '0) ? CMPW'(1) : CMPW'(cfg.image_width);
      height_sat = (cfg.image_height == '0) ? (HB+1)'(1) : {1'b0, cfg.image_height};
      col_next   = CMPW'(col_ff) + CMPW'(1);
      row_next   = {1'b0, row_ff} + (HB+1)'(1);
      last_col   = (col_next >= width_sat) || (col_next >= CMPW'(MAX_WIDTH));
      last_row   = (row_next >= height_sat);
      last_brow  = (brow_ff == BRW'(BLOCK_ROWS - 1));
   end

   // Advance counters on each accepted word
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      brow_in = brow_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               row_in  = '0;
               brow_in = '0;
            end else begin
               row_in  = row_next[HB-1:0];
               brow_in = last_brow ? '0 : brow_ff + BRW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   assign fr_valid_in = accept || (fr_valid_ff && !item_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         brow_ff     <= '0;
         fr_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         brow_ff     <= brow_in;
         fr_valid_ff <= fr_valid_in;
      end
   end

   // Capture the pixel and its marks
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff       <= req_tdata;
         first_row_ff <= (row_ff == '0);
         first_col_ff <= (col_ff == '0);
         row_end_ff   <= last_col;
         block_end_ff <= last_col && (last_row || last_brow);
         frame_end_ff <= last_col && last_row;
      end
   end

   // Line store: read the pixel above and overwrite it in the same cycle
   tlg5pdf_ram #(
      .WIDTH (tlg5pdf_pkg::PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (req_tdata),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (above)
   );

   always_comb begin
      item_valid     = fr_valid_ff;
      item.pixel     = pix_ff;
      item.above     = above;
      item.first_row = first_row_ff;
      item.first_col = first_col_ff;
      item.row_end   = row_end_ff;
      item.block_end = block_end_ff;
      item.frame_end = frame_end_ff;
   end

`ifndef ASSERT_OFF
   a_frame_end_marks: assert property (@(posedge clock) disable iff (reset)
      fr_valid_ff && frame_end_ff |-> row_end_ff && block_end_ff)
      else $error("frame end without row and block end");

   a_col_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && last_col |=> col_ff == '0)
      else $error("column counter did not wrap at row end");
`endif

endmodule

>>> rtl/tlg5pdf_queue.sv
// Short queue between the front end and the back end.
// Depends on tlg5pdf_pkg.
module tlg5pdf_queue #(
   parameter int DEPTH = tlg5pdf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  tlg5pdf_pkg::item_type  push_item,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output tlg5pdf_pkg::item_type  pop_item
);

   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNW = $clog2(DEPTH + 1);

   tlg5pdf_pkg::item_type entry_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNW-1:0] count_ff, count_in;
   logic           push_fire, pop_fire;

   assign push_ready = (count_ff != CNW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + CNW'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - CNW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNW'(DEPTH))
      else $error("queue count beyond depth");

   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      push_fire && !pop_fire |=> count_ff == CNW'($past(count_ff) + CNW'(1)))
      else $error("queue count did not grow on push");
`endif

endmodule

>>> rtl/tlg5pdf_back.sv
// Back end: forms vertical and horizontal deltas, decorrelates colour and
// holds the result word in the output register.
// Depends on tlg5pdf_pkg.
module tlg5pdf_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  item_valid,
   output logic                                  item_ready,
   input  tlg5pdf_pkg::item_type                 item,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [tlg5pdf_pkg::PIXEL_BITS-1:0]    rsp_tdata,
   output logic [tlg5pdf_pkg::USER_BITS-1:0]     rsp_tuser,
   output logic                                  rsp_tlast
);

   localparam int CB = tlg5pdf_pkg::CHANNEL_BITS;
   localparam int NC = tlg5pdf_pkg::CHANNELS;

   logic [NC-1:0][CB-1:0] prior_ff, prior_in;
   logic [NC-1:0][CB-1:0] delta, res;
   logic [tlg5pdf_pkg::PIXEL_BITS-1:0] data_in, out_data_ff;
   logic [tlg5pdf_pkg::USER_BITS-1:0]  out_user_ff;
   logic                               out_last_ff;
   logic                               out_valid_ff, out_valid_in;
   logic                               pop;

   assign item_ready = !out_valid_ff || rsp_tready;
   assign pop        = item_valid && item_ready;

   // Vertical delta, then horizontal residual, per channel
   always_comb begin
      for (int c = 0; c < NC; c++) begin
         delta[c] = item.first_row ? item.pixel[c*CB +: CB]
                                   : item.pixel[c*CB +: CB] - item.above[c*CB +: CB];
         res[c]   = delta[c] - (item.first_col ? CB'(0) : prior_ff[c]);
      end
      prior_in = pop ? delta : prior_ff;
      // Planes: B-G, G, R-G, A
      data_in = {res[3], res[2] - res[1], res[1], res[0] - res[1]};
   end

   assign out_valid_in = pop || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         prior_ff     <= prior_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Load the result word
   always_ff @(posedge clock) begin
      if (pop) begin
         out_data_ff <= data_in;
         out_user_ff <= {item.block_end, item.row_end};
         out_last_ff <= item.frame_end;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
